FILE: src/hhdo_pkg.sv
`default_nettype none
package hhdo_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_TARGET_DISTANCE = 3'd0;
    localparam logic [2:0] CFG_TARGET_HEADING  = 3'd1;
    localparam logic [2:0] CFG_MAX_SPEED       = 3'd2;
    localparam logic [2:0] CFG_REVERSE_DRIVE   = 3'd3;
    localparam logic [2:0] CFG_STEER_GAIN      = 3'd4;
    localparam logic [2:0] CFG_DIST_PER_DEG    = 3'd5;
    localparam logic [2:0] CFG_START_X         = 3'd6;
    localparam logic [2:0] CFG_START_Y         = 3'd7;

    // datapath sequence steps, at most one multiply each
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STP_TRAVEL_MUL = 4'd0;
    localparam logic [STEP_W-1:0] STP_SIN_IDX    = 4'd1;
    localparam logic [STEP_W-1:0] STP_SIN_DIV    = 4'd2;
    localparam logic [STEP_W-1:0] STP_COS_IDX    = 4'd3;
    localparam logic [STEP_W-1:0] STP_COS_DIV    = 4'd4;
    localparam logic [STEP_W-1:0] STP_RAMP_MUL   = 4'd5;
    localparam logic [STEP_W-1:0] STP_RAMP_DIV   = 4'd6;
    localparam logic [STEP_W-1:0] STP_SPEED      = 4'd7;
    localparam logic [STEP_W-1:0] STP_GAIN_MUL   = 4'd8;
    localparam logic [STEP_W-1:0] STP_ERR_MUL    = 4'd9;
    localparam logic [STEP_W-1:0] STP_DELTA_DIV  = 4'd10;
    localparam logic [STEP_W-1:0] STP_SIN_MUL    = 4'd11;
    localparam logic [STEP_W-1:0] STP_COS_MUL    = 4'd12;
    localparam logic [STEP_W-1:0] STP_FINISH     = 4'd13;

    localparam logic [15:0] QUARTER_TURN = 16'd9000;
    localparam logic [15:0] HALF_TURN    = 16'd18000;
    localparam logic [15:0] THREE_QUARTER = 16'd27000;
    localparam logic [15:0] FULL_TURN    = 16'd36000;

    typedef struct packed {
        logic                load;
        logic                calc;
        logic [STEP_W-1:0]   step;
        logic                out_load;
    } t_cmd;

    typedef struct packed {
        logic skip;
    } t_status;

    typedef struct packed {
        logic        neg;
        logic [13:0] arg;
    } t_quarter;

    // fold an angle below a full turn into a quarter-turn argument and sign
    function automatic t_quarter f_quarter(input logic [15:0] ang);
        t_quarter q;
        logic [15:0] v;
        v = 16'd0;
        q.neg = 1'b0;
        if (ang < QUARTER_TURN) begin
            v = ang;
        end else if (ang < HALF_TURN) begin
            v = HALF_TURN - ang;
        end else if (ang < THREE_QUARTER) begin
            v = ang - HALF_TURN;
            q.neg = 1'b1;
        end else begin
            v = FULL_TURN - ang;
            q.neg = 1'b1;
        end
        q.arg = v[13:0];
        return q;
    endfunction

endpackage
`default_nettype wire

FILE: src/hhdo_ctrl.sv
`default_nettype none
module hhdo_ctrl
    import hhdo_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_step = r_step;
        o_cmd.load = 1'b0;
        o_cmd.calc = 1'b0;
        o_cmd.step = r_step;
        o_cmd.out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step = STP_TRAVEL_MUL;
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
                if ((r_step == STP_TRAVEL_MUL && i_status.skip) || r_step == STP_FINISH) begin
                    n_state = ST_WAIT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_WAIT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step <= STP_TRAVEL_MUL;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

FILE: src/hhdo_dpath.sv
`default_nettype none
module hhdo_dpath
    import hhdo_pkg::*;
#(
    parameter int RAMP_INTERVAL = 10,
    parameter int MIN_SPEED     = 10,
    parameter int ERROR_CLAMP   = 15,
    parameter int SINE_DEPTH    = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [23:0]        i_cfg_data,
    input  wire logic [15:0]        i_heading_sample,
    input  wire logic signed [23:0] i_wheel_angle,
    input  wire logic               i_start_move,
    input  wire t_cmd               i_cmd,
    output t_status                 o_status,
    output logic signed [15:0]      o_left_velocity,
    output logic signed [15:0]      o_right_velocity,
    output logic                    o_spin_reverse,
    output logic                    o_move_done,
    output logic signed [31:0]      o_position_x,
    output logic signed [31:0]      o_position_y
);

    localparam int AW = $clog2(SINE_DEPTH);
    localparam int KW = $clog2(SINE_DEPTH + 1);
    localparam logic [15:0] RAMP_LEN = 16'(RAMP_INTERVAL * 256);
    localparam logic [14:0] MIN_Q = 15'(MIN_SPEED * 256);
    localparam logic signed [17:0] CLAMP_Q = 18'(ERROR_CLAMP * 100);
    localparam int S_RI = 31 + $clog2(RAMP_INTERVAL);
    localparam longint M_RI = ((64'sd1 <<< S_RI) + RAMP_INTERVAL - 1) / RAMP_INTERVAL;
    localparam int S_9K = 40;
    localparam longint M_9K = ((64'sd1 <<< S_9K) + 8999) / 9000;
    localparam int S_100 = 35;
    localparam longint M_100 = ((64'sd1 <<< S_100) + 99) / 100;
    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint Q30_HALF_PI = 64'sd1686629713;
    // (2n)(2n+1) for the eight series terms
    localparam longint TAYLOR_DIV [8] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72,
                                          64'sd110, 64'sd156, 64'sd210, 64'sd272};

    typedef logic [15:0] t_sine_rom [SINE_DEPTH];

    // quarter-wave sine in Q1.15 from a Q30 Taylor series
    function automatic t_sine_rom f_build_sine();
        t_sine_rom tab;
        longint x, term, sum, r;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            x = Q30_HALF_PI * k / SINE_DEPTH;
            term = x;
            sum = x;
            for (int n = 1; n <= 8; n++) begin
                term = term * x / Q30_ONE;
                term = term * x / Q30_ONE;
                term = -term / TAYLOR_DIV[n - 1];
                sum = sum + term;
            end
            if (sum < 0) sum = 0;
            r = (sum + 16384) / 32768;
            if (r > 32767) r = 32767;
            tab[k] = 16'(r);
        end
        return tab;
    endfunction

    localparam t_sine_rom SINE_ROM = f_build_sine();

    // configuration
    logic [15:0] r_tgt_dist, r_tgt_head, r_gain;
    logic [14:0] r_max_speed;
    logic        r_reverse;
    logic [23:0] r_dpd, r_start_x, r_start_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_dist <= '0;
            r_tgt_head <= '0;
            r_max_speed <= 15'd12800;
            r_reverse <= 1'b0;
            r_gain <= 16'd1311;
            r_dpd <= 24'd585640;
            r_start_x <= '0;
            r_start_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TARGET_DISTANCE: r_tgt_dist <= i_cfg_data[15:0];
                CFG_TARGET_HEADING:  r_tgt_head <= i_cfg_data[15:0];
                CFG_MAX_SPEED:       r_max_speed <= i_cfg_data[14:0];
                CFG_REVERSE_DRIVE:   r_reverse <= i_cfg_data[0];
                CFG_STEER_GAIN:      r_gain <= i_cfg_data[15:0];
                CFG_DIST_PER_DEG:    r_dpd <= i_cfg_data;
                CFG_START_X:         r_start_x <= i_cfg_data;
                CFG_START_Y:         r_start_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // state and working registers
    logic [23:0]        r_offset, r_prev, r_rel_abs, r_travel;
    logic signed [31:0] r_acc_x, r_acc_y;
    logic               r_finished, r_skip;
    logic               r_sin_neg, r_cos_neg, r_err_neg;
    logic [13:0]        r_sin_arg, r_cos_arg, r_err_abs;
    logic signed [24:0] r_togo;
    logic [24:0]        r_chg_abs;
    logic               r_chg_neg;
    logic               r_ramp_on;
    logic [15:0]        r_fac;
    logic               r_sin_full, r_cos_full;
    logic [15:0]        r_sin_mag, r_cos_mag, r_rom_q;
    logic [14:0]        r_speed;
    logic [21:0]        r_delta;
    logic               r_done;
    logic [63:0]        r_prod;

    // sample capture
    logic [23:0]        off_eff, rel, rel_abs;
    logic               fin_eff;
    logic [15:0]        hmod, cmod_raw, cmod;
    t_quarter           q_sin, q_cos;
    logic signed [17:0] e0, e1, e2, e3;

    assign off_eff = i_start_move ? i_wheel_angle : r_offset;
    assign fin_eff = i_start_move ? (r_tgt_dist == 16'd0) : r_finished;
    assign rel = i_wheel_angle - off_eff;
    assign rel_abs = rel[23] ? (24'd0 - rel) : rel;
    assign hmod = (i_heading_sample >= FULL_TURN) ? (i_heading_sample - FULL_TURN)
                                                  : i_heading_sample;
    assign cmod_raw = hmod + QUARTER_TURN;
    assign cmod = (cmod_raw >= FULL_TURN) ? (cmod_raw - FULL_TURN) : cmod_raw;
    assign q_sin = f_quarter(hmod);
    assign q_cos = f_quarter(cmod);

    always_comb begin
        e0 = $signed({2'b0, i_heading_sample}) - $signed({2'b0, r_tgt_head});
        e1 = (e0 < -18'sd27000) ? (e0 + 18'sd36000) : e0;
        e2 = (e1 > 18'sd27000) ? (e1 - 18'sd36000) : e1;
        e3 = e2;
        if (e2 < -CLAMP_Q) e3 = -CLAMP_Q;
        if (e2 > CLAMP_Q) e3 = CLAMP_Q;
    end

    // shared multiplier operand select
    logic [31:0]      op_a, op_b;
    logic [63:0]      q_ri;
    logic [KW-1:0]    k_idx;
    logic             k_full;
    logic [AW-1:0]    rom_addr;
    logic [23:0]      trav_new;
    logic signed [24:0] chg;
    logic [24:0]      inc_mag;
    logic [31:0]      inc_pos;
    logic [14:0]      spd_raw;

    assign k_idx = KW'(r_prod >> S_9K);
    assign k_full = (k_idx >= KW'(SINE_DEPTH));
    assign rom_addr = k_full ? '0 : k_idx[AW-1:0];
    assign trav_new = (r_prod[63:40] != 24'd0) ? 24'hFFFFFF : r_prod[39:16];
    assign chg = $signed({1'b0, r_travel}) - $signed({1'b0, r_prev});
    assign inc_mag = r_prod[39:15];
    assign inc_pos = {7'd0, inc_mag};
    assign q_ri = r_prod >> S_RI;
    assign spd_raw = r_ramp_on ? q_ri[14:0] : r_max_speed;

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (i_cmd.step)
            STP_TRAVEL_MUL: begin op_a = {8'd0, r_rel_abs}; op_b = {8'd0, r_dpd}; end
            STP_SIN_IDX:    begin op_a = {18'd0, r_sin_arg}; op_b = 32'(SINE_DEPTH); end
            STP_SIN_DIV:    begin op_a = r_prod[31:0]; op_b = 32'(M_9K); end
            STP_COS_IDX:    begin op_a = {18'd0, r_cos_arg}; op_b = 32'(SINE_DEPTH); end
            STP_COS_DIV:    begin op_a = r_prod[31:0]; op_b = 32'(M_9K); end
            STP_RAMP_MUL:   begin op_a = {17'd0, r_max_speed}; op_b = {16'd0, r_fac}; end
            STP_RAMP_DIV:   begin op_a = {8'd0, r_prod[31:8]}; op_b = 32'(M_RI); end
            STP_GAIN_MUL:   begin op_a = {17'd0, r_speed}; op_b = {16'd0, r_gain}; end
            STP_ERR_MUL:    begin op_a = r_prod[31:0]; op_b = {18'd0, r_err_abs}; end
            STP_DELTA_DIV:  begin op_a = r_prod[47:16]; op_b = 32'(M_100); end
            STP_SIN_MUL:    begin op_a = {7'd0, r_chg_abs}; op_b = {16'd0, r_sin_mag}; end
            STP_COS_MUL:    begin op_a = {7'd0, r_chg_abs}; op_b = {16'd0, r_cos_mag}; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rom_q <= SINE_ROM[rom_addr];
        if (i_cmd.calc) begin
            r_prod <= {32'd0, op_a} * {32'd0, op_b};
        end
        if (i_cmd.load) begin
            r_rel_abs <= rel_abs;
            r_sin_neg <= q_sin.neg;
            r_sin_arg <= q_sin.arg;
            r_cos_neg <= q_cos.neg;
            r_cos_arg <= q_cos.arg;
            r_err_neg <= e3[17];
            r_err_abs <= e3[17] ? 14'(-e3) : e3[13:0];
        end
        if (i_cmd.calc) begin
            case (i_cmd.step)
                STP_SIN_IDX: r_travel <= trav_new;
                STP_SIN_DIV: begin
                    r_togo <= $signed({9'd0, r_tgt_dist}) - $signed({1'b0, r_travel});
                    r_chg_neg <= chg[24];
                    r_chg_abs <= chg[24] ? (25'd0 - chg) : chg;
                end
                STP_COS_IDX: begin
                    r_sin_full <= k_full;
                    if (r_togo < $signed({9'd0, RAMP_LEN})) begin
                        r_ramp_on <= 1'b1;
                        r_fac <= (r_togo > 25'sd0) ? r_togo[15:0] : 16'd0;
                    end else if (r_travel < {8'd0, RAMP_LEN}) begin
                        r_ramp_on <= 1'b1;
                        r_fac <= r_travel[15:0];
                    end else begin
                        r_ramp_on <= 1'b0;
                        r_fac <= 16'd0;
                    end
                end
                STP_COS_DIV:  r_sin_mag <= r_sin_full ? 16'h8000 : r_rom_q;
                STP_RAMP_MUL: r_cos_full <= k_full;
                STP_RAMP_DIV: r_cos_mag <= r_cos_full ? 16'h8000 : r_rom_q;
                STP_SPEED:    r_speed <= (spd_raw < MIN_Q) ? MIN_Q : spd_raw;
                STP_SIN_MUL:  r_delta <= r_prod[56:35];
                default: ;
            endcase
        end
    end

    // stored state that reset clears
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_prev <= '0;
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_finished <= 1'b1;
            r_skip <= 1'b1;
            r_done <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_skip <= fin_eff;
                r_finished <= fin_eff;
                if (i_start_move) begin
                    r_offset <= i_wheel_angle;
                    r_prev <= '0;
                    r_acc_x <= {{8{r_start_x[23]}}, r_start_x};
                    r_acc_y <= {{8{r_start_y[23]}}, r_start_y};
                end
            end
            if (i_cmd.calc && i_cmd.step == STP_COS_MUL) begin
                r_acc_x <= r_acc_x + ((r_chg_neg ^ r_sin_neg) ? (32'd0 - inc_pos) : inc_pos);
            end
            if (i_cmd.calc && i_cmd.step == STP_FINISH) begin
                r_acc_y <= r_acc_y + ((r_chg_neg ^ r_cos_neg) ? (32'd0 - inc_pos) : inc_pos);
                r_prev <= r_travel;
                r_done <= (r_togo <= 25'sd0);
                if (r_togo <= 25'sd0) r_finished <= 1'b1;
            end
        end
    end

    // result formation
    logic signed [23:0] d_s, s_s, sum_a, sum_b, lv, rv;

    function automatic logic signed [15:0] f_sat16(input logic signed [23:0] v);
        if (v > 24'sd32767) return 16'sh7FFF;
        if (v < -24'sd32768) return -16'sh8000;
        return v[15:0];
    endfunction

    assign s_s = $signed({9'd0, r_speed});
    assign d_s = r_err_neg ? -$signed({2'b0, r_delta}) : $signed({2'b0, r_delta});
    assign sum_a = s_s - d_s;
    assign sum_b = s_s + d_s;
    assign lv = r_reverse ? sum_b : sum_a;
    assign rv = r_reverse ? sum_a : sum_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_position_x <= r_acc_x;
            o_position_y <= r_acc_y;
            if (r_skip) begin
                o_left_velocity <= '0;
                o_right_velocity <= '0;
                o_spin_reverse <= 1'b0;
                o_move_done <= 1'b1;
            end else begin
                o_left_velocity <= f_sat16(lv);
                o_right_velocity <= f_sat16(rv);
                o_spin_reverse <= r_reverse;
                o_move_done <= r_done;
            end
        end
    end

    assign o_status.skip = r_skip;

endmodule
`default_nettype wire

FILE: src/heading_hold_drive_odometry.sv
// heading_hold_drive_odometry
// Input channel: i_in_valid / o_in_stall carry one request of heading, wheel
// encoder angle and start flag; it is taken when valid is high and stall low.
// Output channel: o_out_valid / i_out_stall carry one result per request:
// left/right velocity, spin direction, done flag and dead-reckoned position.
// Configuration: i_cfg_we writes register i_cfg_idx with i_cfg_data; the user must
// write only while the block is idle, which the block itself does not enforce.
// Timing: a moving request runs 14 steps through one shared 32x32 multiplier
// (travel, sine and cosine index, ramp, steering, two position updates) before
// its result is loaded into the output register; a new request is accepted only
// after that. A request while idle or finished skips the sequence and goes
// straight to the output register; no new request is taken before that either.
// The result sits in an output register; the next request is taken while it
// waits, but its result is held back until the receiver lifts stall.
// Reset: registers return to their defaults, position is zero and the block
// is idle (done) until a request with start set and a nonzero distance.
`default_nettype none
module heading_hold_drive_odometry
    import hhdo_pkg::*;
#(
    parameter int RAMP_INTERVAL = 10,
    parameter int MIN_SPEED     = 10,
    parameter int ERROR_CLAMP   = 15,
    parameter int SINE_DEPTH    = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [23:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [15:0]        i_heading_sample,
    input  wire logic signed [23:0] i_wheel_angle,
    input  wire logic               i_start_move,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [15:0]      o_left_velocity,
    output logic signed [15:0]      o_right_velocity,
    output logic                    o_spin_reverse,
    output logic                    o_move_done,
    output logic signed [31:0]      o_position_x,
    output logic signed [31:0]      o_position_y
);

    t_cmd    cmd;
    t_status status;

    hhdo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    hhdo_dpath #(
        .RAMP_INTERVAL (RAMP_INTERVAL),
        .MIN_SPEED     (MIN_SPEED),
        .ERROR_CLAMP   (ERROR_CLAMP),
        .SINE_DEPTH    (SINE_DEPTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_heading_sample (i_heading_sample),
        .i_wheel_angle    (i_wheel_angle),
        .i_start_move     (i_start_move),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_left_velocity  (o_left_velocity),
        .o_right_velocity (o_right_velocity),
        .o_spin_reverse   (o_spin_reverse),
        .o_move_done      (o_move_done),
        .o_position_x     (o_position_x),
        .o_position_y     (o_position_y)
    );

    // a taken request keeps the input side busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after request");

    // no result appears the cycle after a request is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !$rose(o_out_valid))
        else $error("result too early");

    // a new result coincides with the block going idle
    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("result while still busy");

endmodule
`default_nettype wire

FILE: test/testbench.sv
`default_nettype none
module testbench;
    import hhdo_pkg::*;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               spin;
        logic               done;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } t_drive_cmd;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = 3'd0;
    logic [23:0]        i_cfg_data = 24'd0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [15:0]        i_heading_sample = 16'd0;
    logic signed [23:0] i_wheel_angle = 24'sd0;
    logic               i_start_move = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [15:0] o_left_velocity;
    logic signed [15:0] o_right_velocity;
    logic               o_spin_reverse;
    logic               o_move_done;
    logic signed [31:0] o_position_x;
    logic signed [31:0] o_position_y;

    heading_hold_drive_odometry dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow registers and motion state
    logic [15:0] m_target_dist, m_target_head, m_steer_gain;
    logic [14:0] m_max_speed;
    logic        m_reverse;
    logic [23:0] m_dist_per_deg, m_start_x, m_start_y;
    logic [23:0] m_enc_offset, m_prev_travel;
    logic [31:0] m_acc_x, m_acc_y;
    logic        m_finished;
    logic [15:0] sine_lut [0:1023];

    t_drive_cmd pending_cmds[$];
    int send_gap_pct = 0, recv_stall_pct = 0, hold_cycles = 0;
    int mismatches = 0, n_sent = 0, n_checked = 0, n_moves_done = 0;

    task automatic build_sine_lut();
        longint x, term, sum, r;
        for (int k = 0; k < 1024; k++) begin
            x = 64'sd1686629713 * k / 1024;
            term = x;
            sum = x;
            for (int n = 1; n <= 8; n++) begin
                term = term * x / 64'sd1073741824;
                term = term * x / 64'sd1073741824;
                term = -term / ((2 * n) * (2 * n + 1));
                sum += term;
            end
            if (sum < 0) sum = 0;
            r = (sum + 16384) / 32768;
            if (r > 32767) r = 32767;
            sine_lut[k] = r[15:0];
        end
    endtask

    function automatic longint quarter_sine(longint r);
        longint k;
        k = r * 1024 / 9000;
        if (k >= 1024) return 32768;
        if (k < 0) k = 0;
        return longint'(sine_lut[k]);
    endfunction

    function automatic longint heading_sine(longint h);
        longint q, r;
        q = h / 9000;
        r = h % 9000;
        case (q)
            0: return quarter_sine(r);
            1: return quarter_sine(9000 - r);
            2: return -quarter_sine(r);
            default: return -quarter_sine(9000 - r);
        endcase
    endfunction

    function automatic longint sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    task automatic reset_drive_model();
        m_target_dist = 0; m_target_head = 0; m_max_speed = 12800; m_reverse = 0;
        m_steer_gain = 1311; m_dist_per_deg = 585640; m_start_x = 0; m_start_y = 0;
        m_enc_offset = 0; m_prev_travel = 0; m_acc_x = 0; m_acc_y = 0;
        m_finished = 1'b1;
    endtask

    // next drive command for one accepted sample
    task automatic predict_drive(input logic [15:0] head, input logic [23:0] wheel,
                                 input logic start);
        t_drive_cmd c;
        logic [23:0] d;
        longint rel, travel, to_go, err, speed, delta, changed, hmod;
        c = '0;
        if (start) begin
            m_enc_offset = wheel;
            m_prev_travel = 0;
            m_acc_x = {{8{m_start_x[23]}}, m_start_x};
            m_acc_y = {{8{m_start_y[23]}}, m_start_y};
            m_finished = (m_target_dist == 0);
        end
        if (m_finished) begin
            c.done = 1'b1;
        end else begin
            d = wheel - m_enc_offset;
            rel = longint'($signed(d));
            if (rel < 0) rel = -rel;
            travel = (rel * longint'(m_dist_per_deg)) >>> 16;
            if (travel > 64'hFFFFFF) travel = 64'hFFFFFF;
            to_go = longint'(m_target_dist) - travel;
            err = longint'(head) - longint'(m_target_head);
            if (err < -27000) err += 36000;
            if (err > 27000) err -= 36000;
            if (err < -1500) err = -1500;
            if (err > 1500) err = 1500;
            speed = m_max_speed;
            if (travel < 2560) speed = longint'(m_max_speed) * travel / 2560;
            if (to_go < 2560) speed = to_go > 0 ? longint'(m_max_speed) * to_go / 2560 : 0;
            if (speed < 2560) speed = 2560;
            delta = speed * longint'(m_steer_gain) * err / 6553600;
            c.left = 16'(sat16(m_reverse ? speed + delta : speed - delta));
            c.right = 16'(sat16(m_reverse ? speed - delta : speed + delta));
            c.spin = m_reverse;
            hmod = longint'(head) % 36000;
            changed = travel - longint'(m_prev_travel);
            m_acc_x = m_acc_x + 32'(changed * heading_sine(hmod) / 32768);
            m_acc_y = m_acc_y + 32'(changed * heading_sine((hmod + 9000) % 36000) / 32768);
            m_prev_travel = travel[23:0];
            if (to_go <= 0) begin
                m_finished = 1'b1;
                c.done = 1'b1;
                n_moves_done++;
            end
        end
        c.pos_x = m_acc_x;
        c.pos_y = m_acc_y;
        pending_cmds.push_back(c);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_TARGET_DISTANCE: m_target_dist = val[15:0];
            CFG_TARGET_HEADING:  m_target_head = val[15:0];
            CFG_MAX_SPEED:       m_max_speed = val[14:0];
            CFG_REVERSE_DRIVE:   m_reverse = val[0];
            CFG_STEER_GAIN:      m_steer_gain = val[15:0];
            CFG_DIST_PER_DEG:    m_dist_per_deg = val;
            CFG_START_X:         m_start_x = val;
            default:             m_start_y = val;
        endcase
    endtask

    task automatic write_all(input logic [15:0] td, input logic [15:0] th,
                             input logic [14:0] ms, input logic rv, input logic [15:0] g,
                             input logic [23:0] dpd, input logic [23:0] sx,
                             input logic [23:0] sy);
        write_reg(CFG_TARGET_DISTANCE, {8'd0, td});
        write_reg(CFG_TARGET_HEADING, {8'd0, th});
        write_reg(CFG_MAX_SPEED, {9'd0, ms});
        write_reg(CFG_REVERSE_DRIVE, {23'd0, rv});
        write_reg(CFG_STEER_GAIN, {8'd0, g});
        write_reg(CFG_DIST_PER_DEG, dpd);
        write_reg(CFG_START_X, sx);
        write_reg(CFG_START_Y, sy);
    endtask

    task automatic send_sample(input logic [15:0] head, input logic [23:0] wheel,
                               input logic start);
        if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_heading_sample <= head;
        i_wheel_angle <= wheel;
        i_start_move <= start;
        do @(posedge i_clk); while (o_in_stall);
        predict_drive(head, wheel, start);
        n_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_cmds.size() > 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_drive_cmd c;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_cmds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
            end else begin
                c = pending_cmds.pop_front();
                n_checked++;
                if (o_left_velocity !== c.left || o_right_velocity !== c.right ||
                    o_spin_reverse !== c.spin || o_move_done !== c.done ||
                    o_position_x !== c.pos_x || o_position_y !== c.pos_y) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch #%0d: exp l=%0d r=%0d s=%0d d=%0d x=%0d y=%0d got l=%0d r=%0d s=%0d d=%0d x=%0d y=%0d",
                                 n_checked, c.left, c.right, c.spin, c.done, c.pos_x,
                                 c.pos_y, o_left_velocity, o_right_velocity,
                                 o_spin_reverse, o_move_done, o_position_x, o_position_y);
                end
            end
        end
    end

    task automatic test_directed();
        write_all(16'd3000, 16'd35999, 15'd25600, 1'b0, 16'hFFFF, 24'hFFFFFF,
                  24'h7FFFFF, 24'h800000);
        send_sample(16'd0, 24'sd0, 1'b0);             // idle before any start
        send_sample(16'd0, 24'h7FFFFF, 1'b1);         // heading wraps across north
        send_sample(16'd35999, 24'h7FFFFF, 1'b0);
        send_sample(16'd65535, 24'h800000, 1'b0);     // offset wraps; travel clamps on the next sample
        send_sample(16'd100, 24'sd0, 1'b0);
        drain();
        write_reg(CFG_TARGET_DISTANCE, 24'd0);
        send_sample(16'd9000, 24'sd5, 1'b1);          // zero target finishes at once
        send_sample(16'd18000, 24'sd50, 1'b0);
        drain();
        write_all(16'd65535, 16'd18000, 15'd0, 1'b1, 16'd0, 24'd585640, 24'd0, 24'd0);
        send_sample(16'd18000, 24'sd1000, 1'b1);
        send_sample(16'd27000, 24'sd1200, 1'b0);
        send_sample(16'd9000, 24'sd900, 1'b0);        // encoder running backwards
        send_sample(16'd0, 24'sd400, 1'b0);
        drain();
        write_all(16'd4000, 16'd100, 15'd12800, 1'b1, 16'd1311, 24'd585640,
                  24'h000100, 24'hFFFF00);
        send_sample(16'd35900, 24'sd0, 1'b1);
        for (int i = 1; i <= 7; i++) send_sample(16'(100 + 700 * i), 24'(i * 80), 1'b0);
        drain();
    endtask

    task automatic random_phase(input int n_items, input bit extreme);
        logic [15:0] td, g;
        logic [23:0] dpd, wheel;
        longint step_deg;
        int left;
        td = extreme ? 16'd65535 : 16'($urandom_range(65535));
        if ($urandom_range(3) == 0) td = 16'($urandom_range(6000));
        dpd = ($urandom_range(2) == 0) ? 24'($urandom) : 24'($urandom_range(200000, 2000000));
        if (extreme) dpd = 24'd585640;
        g = extreme ? 16'hFFFF : 16'($urandom);
        write_all(td, 16'($urandom_range(35999)), extreme ? 15'd25600 : 15'($urandom_range(25600)),
                  1'($urandom), g, dpd, 24'($urandom), 24'($urandom));
        step_deg = (longint'(td) * 65536 / (longint'(dpd) + 1)) / 12 + 1;
        if (step_deg > 64'h3FFFFF) step_deg = 64'h3FFFFF;
        left = n_items;
        wheel = 24'($urandom);
        while (left > 0) begin
            if ($urandom_range(9) == 0) begin
                send_sample(16'($urandom), 24'($urandom), 1'($urandom));   // noise
            end else begin
                wheel = 24'($urandom);
                send_sample(16'($urandom_range(35999)), wheel, 1'b1);
                left--;
                for (int s = 0; s < 18 && left > 0; s++) begin
                    if ($urandom_range(9) == 0) wheel = wheel - 24'($urandom_range(step_deg));
                    else wheel = wheel + 24'($urandom_range(2 * step_deg));
                    send_sample(($urandom_range(15) == 0) ? 16'($urandom)
                                : 16'((m_target_head + 36000 + $urandom_range(4000) - 2000)
                                      % 36000), wheel, 1'b0);
                    left--;
                end
            end
            left--;
        end
        drain();
    endtask

    task automatic test_backpressure();
        write_all(16'd65535, 16'd0, 15'd12800, 1'b0, 16'd1311, 24'd585640, 24'd0, 24'd0);
        send_sample(16'd0, 24'sd0, 1'b1);
        hold_cycles = 400;
        for (int i = 1; i <= 20; i++) send_sample(16'(i * 50), 24'(i * 30), 1'b0);
        drain();
        for (int i = 21; i <= 25; i++) send_sample(16'(i * 50), 24'(i * 30), 1'b0);
        drain();
    endtask

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        build_sine_lut();
        reset_drive_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);
        test_directed();
        send_gap_pct = 16; recv_stall_pct = 58;
        random_phase(150, 1'b1);
        send_gap_pct = 58; recv_stall_pct = 16;
        random_phase(150, 1'b0);
        send_gap_pct = 0; recv_stall_pct = 0;
        random_phase(150, 1'b0);
        test_backpressure();
        $display("covered %0d samples, %0d results checked, %0d moves completed",
                 n_sent, n_checked, n_moves_done);
        $display("directed extremes, random moves under idling and a long output hold");
        if (mismatches == 0 && pending_cmds.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
